[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/ncp_pkg.sv]
// ---------------------------------------------------------------------------
// ncp_pkg
// Types and constants of the nearest candidate point block.
// ---------------------------------------------------------------------------
package ncp_pkg;

  localparam int POINT_COUNT = 1024;
  localparam int ADDR_BITS   = $clog2(POINT_COUNT);
  localparam int INDEX_BITS  = 10;
  localparam int COORD_BITS  = 24;
  localparam int SQ_BITS     = 2 * COORD_BITS + 1;  // one squared term / result
  localparam int SUM_BITS    = 2 * COORD_BITS + 2;  // sum of two squares

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    point_t               point;
  } wr_req_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr_a;
    logic [ADDR_BITS-1:0] addr_b;
  } rd_req_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_ACC  = 3'b100
  } state_t;

endpackage

[hw/rtl/nearest_candidate_point_top.sv]
// ---------------------------------------------------------------------------
// nearest_candidate_point_top
// Nearest point to a reference among a run of candidates (squared distance).
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries two kinds of request.
//   func = load writes x_coord / y_coord into entry point_index; a query
//   in the next cycle already sees the new point.
//   func = query presents one candidate (point_index) against a reference
//   (ref_index). A run of candidates ends with last_candidate = 1, which
//   produces one result on the output channel (out_valid / out_ready):
//   nearest_index and nearest_sq_distance. Ties keep the earlier candidate.
//   Occupancy: a query holds the block through table read, squaring, and
//   sum and compare; in_ready is low during squaring and compare. A final
//   candidate's result passes the table read, squaring and output registers.
//   One query at a time runs the single-item path through the table read
//   port, the two 25x25 multipliers and the running-minimum compare.
//   Stall: the result sits in an output register, so further requests are
//   taken while it waits; only a second final candidate waits in the
//   compare stage until the output register is free.
//   Reset (rst, synchronous): clears the run and the output; the point
//   table keeps its contents and is undefined until loaded.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_candidate_point_top
  import ncp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [INDEX_BITS-1:0]        point_index,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  input  logic [INDEX_BITS-1:0]        ref_index,
  input  logic                         last_candidate,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [INDEX_BITS-1:0]        nearest_index,
  output logic [SQ_BITS-1:0]           nearest_sq_distance
);

  state_t state;
  state_t state_next;

  wr_req_t wr;
  rd_req_t rd;
  point_t  cand_pt;
  point_t  ref_pt;

  logic in_take;

  // per-item context carried through the stages
  logic [INDEX_BITS-1:0] mul_index;
  logic                  mul_last;
  logic [INDEX_BITS-1:0] acc_index;
  logic                  acc_last;

  // squaring stage
  logic signed [COORD_BITS:0]     dx;
  logic signed [COORD_BITS:0]     dy;
  logic signed [2*COORD_BITS+1:0] px;
  logic signed [2*COORD_BITS+1:0] py;
  logic [SQ_BITS-1:0]             sq_x;
  logic [SQ_BITS-1:0]             sq_y;

  // compare stage
  logic [SUM_BITS-1:0]   sum;
  logic [SUM_BITS-1:0]   best_dist;
  logic [SUM_BITS-1:0]   best_dist_next;
  logic [INDEX_BITS-1:0] best_index;
  logic [INDEX_BITS-1:0] best_index_next;
  logic                  run_started;
  logic                  acc_go;

  assign in_ready = (state == S_IDLE);
  assign in_take  = in_valid && in_ready;

  // load writes; a query reads candidate and reference together
  assign wr.en     = in_take && (func == FUNC_LOAD);
  assign wr.addr   = point_index[ADDR_BITS-1:0];
  assign wr.point  = '{x: x_coord, y: y_coord};
  assign rd.en     = in_take && (func == FUNC_QUERY);
  assign rd.addr_a = point_index[ADDR_BITS-1:0];
  assign rd.addr_b = ref_index[ADDR_BITS-1:0];

  ncp_point_store u_store (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rd_a (cand_pt),
    .rd_b (ref_pt)
  );

  // the compare stage waits only when it must emit and the output is full
  assign acc_go = !acc_last || !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (rd.en) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        if (acc_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      mul_index <= point_index;
      mul_last  <= last_candidate;
    end
  end

  // differences need one extra bit; squares are non-negative and fit SQ_BITS
  assign dx = {cand_pt.x[COORD_BITS-1], cand_pt.x} - {ref_pt.x[COORD_BITS-1], ref_pt.x};
  assign dy = {cand_pt.y[COORD_BITS-1], cand_pt.y} - {ref_pt.y[COORD_BITS-1], ref_pt.y};
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      sq_x      <= px[SQ_BITS-1:0];
      sq_y      <= py[SQ_BITS-1:0];
      acc_index <= mul_index;
      acc_last  <= mul_last;
    end
  end

  assign sum = {1'b0, sq_x} + {1'b0, sq_y};

  // strict less-than: a tie keeps the earlier candidate
  always_comb begin
    best_dist_next  = best_dist;
    best_index_next = best_index;
    if (!run_started || (sum < best_dist)) begin
      best_dist_next  = sum;
      best_index_next = acc_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist   <= '0;
      best_index  <= '0;
      run_started <= 1'b0;
    end else if ((state == S_ACC) && acc_go) begin
      best_dist   <= best_dist_next;
      best_index  <= best_index_next;
      run_started <= !acc_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_ACC) && acc_go && acc_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_ACC) && acc_go && acc_last) begin
      nearest_index       <= best_index_next;
      nearest_sq_distance <= best_dist_next[SQ_BITS-1:0];
    end
  end

  // a result appears only from the compare stage of a final candidate
  `ASSERT_IMP(a_out_src, clk, rst, $rose(out_valid), $past(state == S_ACC) && $past(acc_last))
  // sum of two squares never exceeds 2**(SQ_BITS)
  `ASSERT_IMP(a_sum_range, clk, rst, (state == S_ACC) && sum[SUM_BITS-1], sum[SUM_BITS-2:0] == '0)
  // an accepted query blocks the input until its compare stage is done
  `ASSERT_NXT(a_query_busy, clk, rst, rd.en, !in_ready && (state == S_MUL))

endmodule

[hw/rtl/ncp_point_store.sv]
// ---------------------------------------------------------------------------
// ncp_point_store
// Point table: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module ncp_point_store
  import ncp_pkg::*;
(
  input  logic    clk,
  input  wr_req_t wr,
  input  rd_req_t rd,
  output point_t  rd_a,
  output point_t  rd_b
);

  point_t mem [POINT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.point;
    end
  end

  // read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_a <= mem[rd.addr_a];
      rd_b <= mem[rd.addr_b];
    end
  end

endmodule
